// ----- rtl/core/ring_buffer_deque_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the ring buffer deque
// Each macro expands to one labeled concurrent assertion clocked on clk and
// disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef RING_BUFFER_DEQUE_MACROS_SVH
`define RING_BUFFER_DEQUE_MACROS_SVH

// Same-cycle implication.
`define RBD_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define RBD_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/rbd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbd_pkg
// Shared types and codes of the ring buffer deque.
// ----------------------------------------------------------------------------
package rbd_pkg;

	localparam int DATA_W   = 32;
	localparam int OP_W     = 3;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 5;

	// Operation codes; unused codes behave as status only.
	localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
	localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
	localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
	localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
	localparam logic [OP_W-1:0] OP_STATUS     = 3'd4;

	// Result status codes.
	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_EXEC = 4'b0010,
		S_READ = 4'b0100,
		S_LOAD = 4'b1000
	} rbd_state_t;

	// Controller to datapath.
	typedef struct packed {
		logic                capture;
		logic                push_front;
		logic                push_back;
		logic                pop_front;
		logic                pop_back;
		logic                read;
		logic                load;
		logic [STATUS_W-1:0] status;
	} rbd_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            full;
		logic            empty;
	} rbd_stat_t;

endpackage

// ----- rtl/core/rbd_req_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbd_req_if
// Request channel: one deque operation per item.
// ----------------------------------------------------------------------------
interface rbd_req_if;
	logic                                valid;
	logic                                ready;
	logic [rbd_pkg::OP_W-1:0]            operation;
	logic signed [rbd_pkg::DATA_W-1:0]   value;

	modport source (output valid, output operation, output value, input ready);
	modport sink   (input valid, input operation, input value, output ready);
endinterface

// ----- rtl/core/rbd_rsp_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbd_rsp_if
// Response channel: one result item per request item.
// ----------------------------------------------------------------------------
interface rbd_rsp_if;
	logic                                valid;
	logic                                ready;
	logic [rbd_pkg::STATUS_W-1:0]        status;
	logic signed [rbd_pkg::DATA_W-1:0]   front_value;
	logic signed [rbd_pkg::DATA_W-1:0]   back_value;
	logic [rbd_pkg::COUNT_W-1:0]         count;
	logic                                is_empty;

	modport source (output valid, output status, output front_value, output back_value,
		output count, output is_empty, input ready);
	modport sink   (input valid, input status, input front_value, input back_value,
		input count, input is_empty, output ready);
endinterface

// ----- rtl/core/rbd_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbd_ctrl
// Sequencer: accept, execute, read back, load the result register.
// ----------------------------------------------------------------------------
module rbd_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	input  rbd_pkg::rbd_stat_t stat,
	output rbd_pkg::rbd_cmd_t  cmd
);
	import rbd_pkg::*;

	rbd_state_t          state_q;
	rbd_state_t          state_d;
	logic                rsp_valid_q;
	logic [STATUS_W-1:0] status_q;
	logic [STATUS_W-1:0] status_d;
	logic                accept;
	logic                out_free;

	assign req_ready = (state_q == S_IDLE);
	assign accept    = req_valid && req_ready;
	assign out_free  = !rsp_valid_q || rsp_ready;
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		cmd        = '0;
		cmd.status = status_q;
		state_d    = state_q;
		status_d   = status_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd.capture = 1'b1;
					state_d     = S_EXEC;
				end
			end
			S_EXEC: begin
				status_d = ST_OK;
				case (stat.op)
					OP_PUSH_FRONT: begin
						if (stat.full) status_d = ST_FULL;
						else cmd.push_front = 1'b1;
					end
					OP_PUSH_BACK: begin
						if (stat.full) status_d = ST_FULL;
						else cmd.push_back = 1'b1;
					end
					OP_POP_FRONT: begin
						if (stat.empty) status_d = ST_EMPTY;
						else cmd.pop_front = 1'b1;
					end
					OP_POP_BACK: begin
						if (stat.empty) status_d = ST_EMPTY;
						else cmd.pop_back = 1'b1;
					end
					default: status_d = ST_OK;
				endcase
				state_d = S_READ;
			end
			S_READ: begin
				cmd.read = 1'b1;
				state_d  = S_LOAD;
			end
			S_LOAD: begin
				// hold until the result register can take the item
				if (out_free) begin
					cmd.load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
			status_q    <= ST_OK;
		end else begin
			state_q  <= state_d;
			status_q <= status_d;
			if (cmd.load) rsp_valid_q <= 1'b1;
			else if (rsp_ready) rsp_valid_q <= 1'b0;
		end
	end

endmodule

// ----- rtl/core/rbd_dpath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbd_dpath
// Element store, head index, element count and the result register.
// ----------------------------------------------------------------------------
module rbd_dpath #(
	parameter int CAPACITY = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [rbd_pkg::OP_W-1:0]            operation,
	input  logic signed [rbd_pkg::DATA_W-1:0]   value,
	input  rbd_pkg::rbd_cmd_t                    cmd,
	output rbd_pkg::rbd_stat_t                   stat,
	output logic [rbd_pkg::STATUS_W-1:0]        status,
	output logic signed [rbd_pkg::DATA_W-1:0]   front_value,
	output logic signed [rbd_pkg::DATA_W-1:0]   back_value,
	output logic [rbd_pkg::COUNT_W-1:0]         count,
	output logic                                is_empty
);
	import rbd_pkg::*;

	localparam int IW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW  = $clog2(CAPACITY + 1);
	localparam int CXW = CW + COUNT_W;

	// (a + b) mod CAPACITY for a, b below CAPACITY
	function automatic logic [IW-1:0] wrap_add(input logic [IW-1:0] a, input logic [IW-1:0] b);
		logic [IW:0] sum;
		sum = {1'b0, a} + {1'b0, b};
		if (sum >= (IW+1)'(CAPACITY)) sum = sum - (IW+1)'(CAPACITY);
		return sum[IW-1:0];
	endfunction

	logic [DATA_W-1:0]   mem [CAPACITY];
	logic [OP_W-1:0]     op_q;
	logic [DATA_W-1:0]   value_q;
	logic [IW-1:0]       head_q;
	logic [CW-1:0]       count_q;
	logic [DATA_W-1:0]   front_rd_q;
	logic [DATA_W-1:0]   back_rd_q;
	logic [STATUS_W-1:0] status_q;
	logic [DATA_W-1:0]   front_q;
	logic [DATA_W-1:0]   back_q;
	logic [COUNT_W-1:0]  count_out_q;
	logic                empty_q;

	logic [IW-1:0]       head_dec;
	logic [IW-1:0]       head_inc;
	logic [IW-1:0]       tail_slot;
	logic [IW-1:0]       last_off;
	logic [IW-1:0]       last_slot;
	logic [IW-1:0]       wr_addr;
	logic                wr_en;
	logic                empty_now;
	logic [CXW-1:0]      count_wide;

	assign empty_now = (count_q == '0);
	assign head_dec  = (head_q == '0) ? IW'(CAPACITY - 1) : head_q - IW'(1);
	assign head_inc  = (head_q == IW'(CAPACITY - 1)) ? '0 : head_q + IW'(1);
	// count is below CAPACITY whenever the tail slot is written
	assign tail_slot = wrap_add(head_q, IW'(count_q));
	assign last_off  = empty_now ? '0 : IW'(count_q - CW'(1));
	assign last_slot = wrap_add(head_q, last_off);
	assign wr_en     = cmd.push_front || cmd.push_back;
	assign wr_addr   = cmd.push_front ? head_dec : tail_slot;
	assign count_wide = CXW'(count_q);

	assign stat.op    = op_q;
	assign stat.full  = (count_q == CW'(CAPACITY));
	assign stat.empty = empty_now;

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= value_q;
		if (cmd.read) begin
			front_rd_q <= mem[head_q];
			back_rd_q  <= mem[last_slot];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q    <= operation;
			value_q <= value;
		end
		if (cmd.load) begin
			status_q    <= cmd.status;
			front_q     <= empty_now ? '0 : front_rd_q;
			back_q      <= empty_now ? '0 : back_rd_q;
			count_out_q <= count_wide[COUNT_W-1:0];
			empty_q     <= empty_now;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
		end else begin
			if (cmd.push_front) head_q <= head_dec;
			else if (cmd.pop_front) head_q <= head_inc;
			if (wr_en) count_q <= count_q + CW'(1);
			else if (cmd.pop_front || cmd.pop_back) count_q <= count_q - CW'(1);
		end
	end

	assign status      = status_q;
	assign front_value = front_q;
	assign back_value  = back_q;
	assign count       = count_out_q;
	assign is_empty    = empty_q;

endmodule

// ----- rtl/core/ring_buffer_deque.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ring_buffer_deque
// Double-ended queue of signed 32-bit values in a circular store.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one item per operation: push front, push back, pop front,
//   pop back or status only, with the value to insert on a push.
//   rsp returns exactly one item per request: status (ok, full, empty),
//   front and back values, element count and an empty flag.
//   An item passes through capture, execute (at most one store write, index
//   and count update), read of front and back through the store's two read
//   ports, then load of the result register. rsp.valid is registered from
//   the load step and req.ready returns in the same cycle, so the block
//   holds one item in flight at a time.
//   The result register decouples the channels: while a result waits on
//   rsp.ready, the next item is accepted and processed up to the load step,
//   where it holds until the waiting result is taken.
//   Reset empties the deque (head and count to zero); store contents are not
//   cleared and need not be, since front and back read as zero in an empty result.
// ----------------------------------------------------------------------------
`include "ring_buffer_deque_macros.svh"

module ring_buffer_deque #(
	parameter int CAPACITY = 16
) (
	input logic      clk,
	input logic      arst_n,
	rbd_req_if.sink   req,
	rbd_rsp_if.source rsp
);
	import rbd_pkg::*;

	rbd_cmd_t  cmd;
	rbd_stat_t stat;

	rbd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	rbd_dpath #(
		.CAPACITY (CAPACITY)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.operation   (req.operation),
		.value       (req.value),
		.cmd         (cmd),
		.stat        (stat),
		.status      (rsp.status),
		.front_value (rsp.front_value),
		.back_value  (rsp.back_value),
		.count       (rsp.count),
		.is_empty    (rsp.is_empty)
	);

	`RBD_ASSERT_NXT(a_one_in_flight, req.valid && req.ready, !req.ready, "second item accepted while one is in flight")
	`RBD_ASSERT_IMP(a_no_push_full, cmd.push_front || cmd.push_back, !stat.full, "push executed into a full store")
	`RBD_ASSERT_IMP(a_no_pop_empty, cmd.pop_front || cmd.pop_back, !stat.empty, "pop executed on an empty store")
	`RBD_ASSERT_IMP(a_empty_flag, rsp.valid && rsp.is_empty, rsp.count == '0 && rsp.status != ST_FULL, "empty result with nonzero count or full status")

endmodule
